>>> hdl/htrc_pkg.sv
// shared types, constants and crc helper for the humidity/temperature converter
package htrc_pkg;

  // widths
  localparam int unsigned DIV_W  = 23;  // divisor (positive linear humidity) width
  localparam int unsigned QUO_W  = 21;  // correction quotient width
  localparam int unsigned PROD_W = 39;  // fraction times divisor
  localparam int unsigned BASE_W = 24;  // signed intermediate reading

  // measurement kinds carried with each request
  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_HUMID = 1'b1;

  // crc-8, polynomial x^8+x^5+x^4+1, msb first
  localparam logic [8:0] CRC_POLY    = 9'h131;
  localparam logic [7:0] STATUS_MASK = 8'hF8;

  // temperature: round(17572*r/65536) - 4685
  localparam logic [14:0]        T_SPAN     = 15'd17572;
  localparam logic [31:0]        ROUND_HALF = 32'd32768;
  localparam logic signed [15:0] T_OFFSET   = 16'sd4685;

  // humidity: hn = 125*r - 6*65536
  localparam logic [6:0]         H_SPAN     = 7'd125;
  localparam logic signed [23:0] H_OFFSET   = 24'sd393216;
  localparam logic [6:0]         HUNDRED    = 7'd100;
  localparam logic signed [23:0] CORR_OFFS  = 24'sd250;
  // 25000 * 65536, divided by hn for the correction term
  localparam logic [30:0]        DIV_NUM    = 31'd1638400000;

  localparam logic signed [15:0] VALUE_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] VALUE_MIN  = 16'sh8000;

  // sideband carried alongside the divider
  typedef struct packed {
    logic                op;
    logic                crc_ok;
    logic                h_pos;
    logic signed [15:0]  t_val;
    logic [13:0]         h_int;
    logic [15:0]         h_frac;
    logic [DIV_W-1:0]    hn;
  } side_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               crc_ok;
    logic               out_of_range;
  } res_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY[7:0];
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> hdl/humidity_temp_reading_convert_unit.sv
// top level: sensor word crc check and conversion to hundredths of degree or percent
// pipeline: 2 front, 21 divider and 3 back stages and the output register lie between an
//   accepted request and out_tvalid; everything stalls while the skid holds a result
// throughput: one request per cycle while the skid slot is free; the correction divider
//   retires one quotient bit per stage, so its 21 stages set the depth, not the rate
// reset: synchronous active-low rst_n clears every stage valid, the output and the skid
module humidity_temp_reading_convert_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // raw_high [7:0], raw_low [15:8], check_byte [23:16]
  input  logic        in_tuser,   // op [0]: 0 temperature, 1 relative humidity
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // value [15:0], signed hundredths
  output logic [1:0]  out_tuser   // crc_ok [0], out_of_range [1]
);
  import htrc_pkg::*;

  // whole pipeline moves together while the skid slot is free
  logic             en;

  logic             fr_valid;
  side_t            fr_side;
  logic             dv_valid;
  side_t            dv_side;
  logic [QUO_W-1:0] dv_quo;
  logic [DIV_W-1:0] dv_rem;
  logic             bk_valid;
  res_t             bk_res;

  // output register plus one skid entry
  logic             out_valid_r;
  res_t             out_res_r;
  logic             skid_valid_r;
  res_t             skid_res_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // crc, masking, temperature and linear humidity
  htrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_high   (in_tdata[7:0]),
    .in_low    (in_tdata[15:8]),
    .in_check  (in_tdata[23:16]),
    .out_valid (fr_valid),
    .out_side  (fr_side)
  );

  // 25000*65536 / hn, quotient and remainder for the humidity correction
  htrc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo),
    .out_rem   (dv_rem)
  );

  // rounding of the corrected reading, selection, saturation
  htrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .in_quo    (dv_quo),
    .in_rem    (dv_rem),
    .out_valid (bk_valid),
    .out_res   (bk_res)
  );

  // a result leaving the pipeline goes to the output register when it is free,
  // otherwise into the skid, which then holds the pipeline until it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= bk_valid;
      end
    end else if (bk_valid && en) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else begin
        out_res_r <= bk_res;
      end
    end else if (bk_valid && en) begin
      skid_res_r <= bk_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = {out_res_r.out_of_range, out_res_r.crc_ok};

endmodule

>>> hdl/htrc_front.sv
// front stages: crc check, status masking, temperature scaling, linear humidity
module htrc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic           in_op,
  input  logic [7:0]     in_high,
  input  logic [7:0]     in_low,
  input  logic [7:0]     in_check,
  output logic           out_valid,
  output htrc_pkg::side_t out_side
);
  import htrc_pkg::*;

  logic [15:0]        raw;
  logic [22:0]        h_span;
  logic               v1_r;
  logic               op1_r;
  logic [7:0]         lo1_r;
  logic [7:0]         chk1_r;
  logic [7:0]         crc1_r;
  logic [30:0]        tprod1_r;
  logic signed [23:0] hn1_r;
  logic               v2_r;
  side_t              side2_r;
  side_t              side2_nxt;
  logic [31:0]        tround;
  logic [29:0]        h100;

  assign raw    = {in_high, in_low & STATUS_MASK};
  assign h_span = 23'(raw) * 23'(H_SPAN);

  // stage 1: first crc byte, scaling products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r    <= in_op;
      lo1_r    <= in_low;
      chk1_r   <= in_check;
      crc1_r   <= crc_byte(in_high);
      tprod1_r <= 31'(raw) * 31'(T_SPAN);
      hn1_r    <= $signed({1'b0, h_span}) - H_OFFSET;
    end
  end

  // stage 2: second crc byte, rounding, humidity times hundred
  assign tround = {1'b0, tprod1_r} + ROUND_HALF;
  assign h100   = 30'(hn1_r[22:0]) * 30'(HUNDRED);

  always_comb begin
    side2_nxt        = '0;
    side2_nxt.op     = op1_r;
    side2_nxt.crc_ok = (crc_byte(crc1_r ^ lo1_r) == chk1_r);
    side2_nxt.h_pos  = !hn1_r[23] && (hn1_r != '0);
    side2_nxt.t_val  = $signed(tround[31:16]) - T_OFFSET;
    side2_nxt.h_int  = h100[29:16];
    side2_nxt.h_frac = h100[15:0];
    side2_nxt.hn     = hn1_r[22:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_side  = side2_r;

endmodule

>>> hdl/htrc_div.sv
// pipelined restoring divider: constant numerator over linear humidity, one bit per stage
module htrc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  htrc_pkg::side_t            in_side,
  output logic                       out_valid,
  output htrc_pkg::side_t            out_side,
  output logic [htrc_pkg::QUO_W-1:0] out_quo,
  output logic [htrc_pkg::DIV_W-1:0] out_rem
);
  import htrc_pkg::*;

  logic             v_in   [QUO_W];
  side_t            side_in[QUO_W];
  logic [DIV_W-1:0] rem_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic             v_r    [QUO_W];
  side_t            side_r [QUO_W];
  logic [DIV_W-1:0] rem_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [DIV_W:0] rem2;
    logic [DIV_W:0] diff;
    logic           ge;

    if (g == 0) begin : g_first
      // numerator bits above the quotient width seed the remainder
      assign v_in[g]    = in_valid;
      assign side_in[g] = in_side;
      assign rem_in[g]  = DIV_W'(DIV_NUM >> QUO_W);
      assign quo_in[g]  = '0;
    end else begin : g_next
      assign v_in[g]    = v_r[g-1];
      assign side_in[g] = side_r[g-1];
      assign rem_in[g]  = rem_r[g-1];
      assign quo_in[g]  = quo_r[g-1];
    end

    assign rem2 = {rem_in[g], DIV_NUM[QUO_W-1-g]};
    assign diff = rem2 - {1'b0, side_in[g].hn};
    assign ge   = (rem2 >= {1'b0, side_in[g].hn});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= side_in[g];
        rem_r[g]  <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
        quo_r[g]  <= {quo_in[g][QUO_W-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_rem   = rem_r[QUO_W-1];

endmodule

>>> hdl/htrc_back.sv
// back stages: correction rounding, kind selection and saturation
module htrc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  htrc_pkg::side_t            in_side,
  input  logic [htrc_pkg::QUO_W-1:0] in_quo,
  input  logic [htrc_pkg::DIV_W-1:0] in_rem,
  output logic                       out_valid,
  output htrc_pkg::res_t             out_res
);
  import htrc_pkg::*;

  // stage 1: fraction product, integer part
  logic                     v1_r;
  logic                     op1_r, ok1_r, pos1_r;
  logic signed [15:0]       tval1_r;
  logic [DIV_W-1:0]         hn1_r;
  logic [DIV_W-1:0]         rem1_r;
  logic [PROD_W-1:0]        prod1_r;
  logic signed [BASE_W-1:0] base1_r;
  logic signed [BASE_W-1:0] base_nxt;

  assign base_nxt = $signed(BASE_W'(in_side.h_int)) - $signed(BASE_W'(in_quo)) + CORR_OFFS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_side.op;
      ok1_r   <= in_side.crc_ok;
      pos1_r  <= in_side.h_pos;
      tval1_r <= in_side.t_val;
      hn1_r   <= in_side.hn;
      rem1_r  <= in_rem;
      prod1_r <= PROD_W'(in_side.h_frac) * PROD_W'(in_side.hn);
      base1_r <= base_nxt;
    end
  end

  // stage 2: fraction f/65536 + 1/2 - rem/hn decides a step of one either way
  logic [PROD_W:0]          hn_sh, rem_sh, prod_x;
  logic                     up, dn;
  logic signed [BASE_W-1:0] val_nxt;
  logic                     v2_r;
  logic                     op2_r, ok2_r, pos2_r;
  logic signed [15:0]       tval2_r;
  logic signed [BASE_W-1:0] val2_r;

  assign hn_sh   = (PROD_W+1)'({hn1_r, 15'b0});
  assign rem_sh  = (PROD_W+1)'({rem1_r, 16'b0});
  assign prod_x  = (PROD_W+1)'(prod1_r);
  assign up      = (prod_x >= hn_sh + rem_sh);
  assign dn      = (prod_x + hn_sh < rem_sh);
  assign val_nxt = base1_r + $signed(BASE_W'(up)) - $signed(BASE_W'(dn));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r   <= op1_r;
      ok2_r   <= ok1_r;
      pos2_r  <= pos1_r;
      tval2_r <= tval1_r;
      val2_r  <= val_nxt;
    end
  end

  // stage 3: select and saturate
  logic v3_r;
  res_t res3_r;
  res_t res_nxt;

  always_comb begin
    res_nxt = '0;
    if (!ok2_r) begin
      res_nxt = '0;
    end else if (op2_r == OP_TEMP) begin
      res_nxt.crc_ok = 1'b1;
      res_nxt.value  = tval2_r;
    end else if (!pos2_r) begin
      res_nxt.crc_ok       = 1'b1;
      res_nxt.value        = VALUE_MIN;
      res_nxt.out_of_range = 1'b1;
    end else if (val2_r > BASE_W'(VALUE_MAX)) begin
      res_nxt.crc_ok       = 1'b1;
      res_nxt.value        = VALUE_MAX;
      res_nxt.out_of_range = 1'b1;
    end else if (val2_r < BASE_W'(VALUE_MIN)) begin
      res_nxt.crc_ok       = 1'b1;
      res_nxt.value        = VALUE_MIN;
      res_nxt.out_of_range = 1'b1;
    end else begin
      res_nxt.crc_ok = 1'b1;
      res_nxt.value  = val2_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res3_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_res   = res3_r;

endmodule

>>> hdl/htrc_checker.sv
// port-level checks for the converter, bound to the top level
module htrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("request changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // failed check gives zero and no range flag
  a_crc_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'h0000 && !out_tuser[1])
    else $error("crc failure result not cleared");

  // range flag only with a saturated value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 16'h8000 || out_tdata == 16'h7FFF)
    else $error("out of range without saturated value");

  // input side only stalls after output back-pressure
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tready |=> in_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind humidity_temp_reading_convert_unit htrc_checker u_htrc_checker (.*);

>>> test/testbench.sv
// self-checking bench for the sensor word crc check and reading conversion unit
`timescale 1ns / 100ps

module testbench;
  import htrc_pkg::*;

  // conversion constants, all in exact integer form
  localparam longint FULL_SCALE   = 65536;
  localparam longint T_SPAN_C     = 17572;
  localparam longint T_OFFSET_C   = 4685;
  localparam longint H_SPAN_C     = 125;
  localparam longint H_OFFSET_C   = 6;
  localparam longint HUNDREDTHS_C = 100;
  localparam longint CORR_HALF_C  = 250;
  localparam longint CORR_NUM_C   = 25000;
  localparam longint READING_MAX  = 32767;
  localparam longint READING_MIN  = -32768;

  localparam int RANDOM_READINGS = 1150;
  localparam int CALM_FROM       = 1000;  // no idling on either side from here on
  localparam int DRAIN_AT        = 500;   // sender holds off until all results are back
  localparam int SETTLE_CYCLES   = 40;    // pipeline depth plus margin

  // how a stimulus row gets its check byte
  typedef enum logic [1:0] {
    CHK_GOOD,   // correct crc over the two raw bytes
    CHK_BAD,    // correct crc with several bits flipped
    CHK_GIVEN   // check byte taken from the row as it stands
  } check_mode_t;

  typedef struct {
    logic        op;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  chk;
    check_mode_t mode;
    bit          typed;  // expected result written into the row by hand
    res_t        want;
  } reading_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // raw_high [7:0], raw_low [15:8], check_byte [23:16]
  logic        in_tuser;   // op [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // value [15:0]
  logic [1:0]  out_tuser;  // crc_ok [0], out_of_range [1]

  res_t         pending_readings[$];  // expected results, oldest first
  reading_row_t directed_rows[$];
  bit           calm;
  int           mismatches;
  int           results_seen;
  int           crc_failures;
  int           saturated;
  int           humid_results;

  humidity_temp_reading_convert_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // crc-8 over the 16 raw bits, msb first, poly 0x31, init 0, worked bit-serially
  function automatic logic [7:0] sensor_crc8(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] word;
    logic [7:0]  crc;
    logic        fb;
    word = {hi, lo};
    crc  = 8'h00;
    for (int b = 15; b >= 0; b--) begin
      fb  = crc[7] ^ word[b];
      crc = {crc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
    end
    return crc;
  endfunction

  // nearest, ties upward: floor((2n + d) / 2d) with d positive
  function automatic longint round_half_up(input longint n, input longint d);
    longint num;
    longint den;
    longint q;
    num = 2 * n + d;
    den = 2 * d;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // expected result for one raw sensor word
  function automatic res_t convert_reading(input logic op, input logic [7:0] hi,
                                           input logic [7:0] lo, input logic [7:0] chk);
    res_t   res;
    longint raw;
    longint hn;
    longint num;
    longint v;
    res = '0;
    if (sensor_crc8(hi, lo) != chk) return res;
    res.crc_ok = 1'b1;
    raw = longint'({hi, lo & 8'hF8});
    if (op == OP_TEMP) begin
      v = round_half_up(T_SPAN_C * raw, FULL_SCALE) - T_OFFSET_C;
    end else begin
      hn = H_SPAN_C * raw - H_OFFSET_C * FULL_SCALE;
      if (hn <= 0) begin
        // no meaningful correction below zero linear humidity
        v = READING_MIN;
        res.out_of_range = 1'b1;
      end else begin
        num = HUNDREDTHS_C * hn * hn + CORR_HALF_C * FULL_SCALE * hn
              - CORR_NUM_C * FULL_SCALE * FULL_SCALE;
        v = round_half_up(num, FULL_SCALE * hn);
      end
    end
    if (v > READING_MAX) begin
      v = READING_MAX;
      res.out_of_range = 1'b1;
    end else if (v < READING_MIN) begin
      v = READING_MIN;
      res.out_of_range = 1'b1;
    end
    res.value = v[15:0];
    return res;
  endfunction

  task automatic add_row(input logic op, input logic [7:0] hi, input logic [7:0] lo,
                         input logic [7:0] chk, input check_mode_t mode, input bit typed,
                         input logic signed [15:0] value, input logic ok, input logic oor);
    reading_row_t row;
    row.op   = op;
    row.hi   = hi;
    row.lo   = lo;
    row.chk  = chk;
    row.mode = mode;
    row.typed = typed;
    row.want.value = value;
    row.want.crc_ok = ok;
    row.want.out_of_range = oor;
    directed_rows.push_back(row);
  endtask

  // present one request from a falling edge, hold until taken, log what should come back
  task automatic issue_reading(input logic op, input logic [7:0] hi, input logic [7:0] lo,
                               input logic [7:0] chk, input res_t want);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {chk, lo, hi};
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(want);
    @(negedge clk);
  endtask

  // occasional sender gap, only while not calm
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // hold the sender off until every outstanding result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  // receiver side: ready drops in short random bursts, never once things go calm
  initial begin
    out_tready = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result value=%0d crc_ok=%b oor=%b", $realtime,
                   $signed(out_tdata), out_tuser[0], out_tuser[1]);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (!want.crc_ok) crc_failures++;
        if (want.out_of_range) saturated++;
        if ($signed(out_tdata) !== want.value || out_tuser[0] !== want.crc_ok ||
            out_tuser[1] !== want.out_of_range) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp value=%0d crc_ok=%b oor=%b, got value=%0d crc_ok=%b oor=%b",
                     $realtime, want.value, want.crc_ok, want.out_of_range,
                     $signed(out_tdata), out_tuser[0], out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // stimulus: directed table, then random words, then drain and report
  initial begin : stimulus
    reading_row_t row;
    res_t         want;
    logic         op;
    logic [7:0]   hi;
    logic [7:0]   lo;
    logic [7:0]   chk;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    calm       = 1'b0;
    mismatches = 0;
    results_seen  = 0;
    crc_failures  = 0;
    saturated     = 0;
    humid_results = 0;

    // zero words: crc of two zero bytes is zero
    add_row(OP_TEMP,  8'h00, 8'h00, 8'h00, CHK_GIVEN, 1, -16'sd4685,  1'b1, 1'b0);
    add_row(OP_HUMID, 8'h00, 8'h00, 8'h00, CHK_GIVEN, 1, -16'sd32768, 1'b1, 1'b1);
    // status bits alone do not move the reading
    add_row(OP_TEMP,  8'h00, 8'h07, 8'h00, CHK_GOOD,  1, -16'sd4685,  1'b1, 1'b0);
    // full scale, with and without status bits
    add_row(OP_TEMP,  8'hFF, 8'hFF, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_TEMP,  8'hFF, 8'hF8, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'hFF, 8'hFF, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'hFF, 8'hF8, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    // check failures give a zero reading for both kinds
    add_row(OP_TEMP,  8'h12, 8'h34, 8'h00, CHK_BAD,   1, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'hAB, 8'hCD, 8'h00, CHK_BAD,   1, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'hFF, 8'hFF, 8'h00, CHK_BAD,   1, 16'sd0, 1'b0, 1'b0);
    add_row(OP_TEMP,  8'h00, 8'h00, 8'hFF, CHK_GIVEN, 1, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'h00, 8'h00, 8'h80, CHK_GIVEN, 1, 16'sd0, 1'b0, 1'b0);
    // linear humidity just below zero
    add_row(OP_HUMID, 8'h0C, 8'h48, 8'h00, CHK_GOOD,  1, -16'sd32768, 1'b1, 1'b1);
    add_row(OP_HUMID, 8'h0C, 8'h4F, 8'h00, CHK_GOOD,  1, -16'sd32768, 1'b1, 1'b1);
    // first positive linear humidity and the climb out of saturation
    add_row(OP_HUMID, 8'h0C, 8'h50, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'h0D, 8'h00, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'h10, 8'h00, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'h20, 8'h00, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_HUMID, 8'h80, 8'h00, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    // temperature mid scale and around zero degrees
    add_row(OP_TEMP,  8'h80, 8'h00, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_TEMP,  8'h44, 8'h44, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);
    add_row(OP_TEMP,  8'h55, 8'hAA, 8'h00, CHK_GOOD,  0, 16'sd0, 1'b0, 1'b0);

    // hold reset low, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      chk = row.chk;
      if (row.mode == CHK_GOOD) chk = sensor_crc8(row.hi, row.lo);
      else if (row.mode == CHK_BAD) chk = sensor_crc8(row.hi, row.lo) ^ 8'hA5;
      want = row.typed ? row.want : convert_reading(row.op, row.hi, row.lo, chk);
      if (row.op == OP_HUMID) humid_results++;
      sender_gap();
      issue_reading(row.op, row.hi, row.lo, chk, want);
    end
    wait_drained();

    // random words: mostly valid check bytes so the conversion paths get exercised
    for (int n = 0; n < RANDOM_READINGS; n++) begin
      if (n == DRAIN_AT) wait_drained();
      calm = (n >= CALM_FROM);
      op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       hi = 8'($urandom_range(8'h0B, 8'h0E));  // around the humidity zero point
        1:       hi = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: hi = 8'($urandom_range(0, 255));
      endcase
      lo  = 8'($urandom_range(0, 255));
      chk = sensor_crc8(hi, lo);
      case ($urandom_range(0, 9))
        0:       chk = 8'($urandom_range(0, 255));
        1:       chk = chk ^ (8'h01 << $urandom_range(0, 7));
        default: ;
      endcase
      if (op == OP_HUMID) humid_results++;
      sender_gap();
      issue_reading(op, hi, lo, chk, convert_reading(op, hi, lo, chk));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random words, %0d of them humidity",
             directed_rows.size(), RANDOM_READINGS, humid_results);
    $display("%0d results checked: %0d check failures, %0d out of range, %0d mismatches",
             results_seen, crc_failures, saturated, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
